// ===== design/gain_scheduled_pid_steering_macros.svh =====
// assertion macros for the steering controller
// used by the top level only, no other dependencies
`ifndef GAIN_SCHEDULED_PID_STEERING_MACROS_SVH
`define GAIN_SCHEDULED_PID_STEERING_MACROS_SVH

// same-cycle implication, checked out of reset
`define GSPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gsps_pkg.sv =====
// shared widths, constants, control word types and microcode rom
// no dependencies
package gsps_pkg;

    // field widths
    localparam int BRIGHT_W   = 7;
    localparam int SEL_W      = 2;
    localparam int DIR_W      = 16;
    localparam int THR_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // error pair sum, kept as quotient and remainder of a division by 500
    localparam int SUM_BITS = 32;
    localparam int SUM_DIV  = 500;
    localparam int SQ_W     = SUM_BITS - 8;
    localparam int SR_W     = 9;

    // datapath widths
    localparam int ERR_W  = 9;
    localparam int DIFF_W = 10;
    localparam int D_W    = 18;
    localparam int U_W    = 25;
    localparam int Q_W    = 16;
    localparam int A_W    = 27;
    localparam int B_W    = ((SQ_W > 27) ? SQ_W : 27) + 1;
    localparam int P_W    = A_W + B_W;
    localparam int ACC_W  = ((SQ_W + 18) > 36) ? (SQ_W + 18) : 36;
    localparam int C_W    = 20;
    localparam int PC_W   = 4;

    // saturation bounds of the sum in quotient / remainder form
    localparam longint SUM_MAX  = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN  = -SUM_MAX - 1;
    localparam longint SQ_MAX_L = SUM_MAX / SUM_DIV;
    localparam longint SR_MAX_L = SUM_MAX % SUM_DIV;
    localparam longint SQ_MIN_L = -((-SUM_MIN + SUM_DIV - 1) / SUM_DIV);
    localparam longint SR_MIN_L = SUM_MIN - SQ_MIN_L * SUM_DIV;

    localparam logic signed [SQ_W-1:0] SQ_MAX = SQ_W'(SQ_MAX_L);
    localparam logic signed [SQ_W-1:0] SQ_MIN = SQ_W'(SQ_MIN_L);
    localparam logic [SR_W-1:0]        SR_MAX = SR_W'(SR_MAX_L);
    localparam logic [SR_W-1:0]        SR_MIN = SR_W'(SR_MIN_L);

    // reciprocal of 500 for the remainder division
    localparam int     RECIP_SHIFT = 34;
    localparam longint RECIP_500   = (longint'(1) <<< RECIP_SHIFT) / SUM_DIV;
    localparam int     ROUND_BIAS  = SUM_DIV / 2;

    // output scaling
    localparam int DIR_LIMIT   = 409600;
    localparam int DIR_Q88_MAX = 25600;
    localparam int Q88_SHIFT   = 4;
    localparam int Q88_BIAS    = 8;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(4096);

    // speed select codes
    localparam logic [SEL_W-1:0] SEL_STOP = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SLOW = 2'd1;
    localparam logic [SEL_W-1:0] SEL_FAST = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_FAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_FAST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_FAST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_SLOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_SLOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_SLOW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_GAIN = 3'd7;

    typedef struct packed {
        logic signed [THR_W-1:0] line_threshold;
        logic [GAIN_W-1:0]       prop_gain_fast;
        logic [GAIN_W-1:0]       integ_gain_fast;
        logic [GAIN_W-1:0]       deriv_gain_fast;
        logic [GAIN_W-1:0]       prop_gain_slow;
        logic [GAIN_W-1:0]       integ_gain_slow;
        logic [GAIN_W-1:0]       deriv_gain_slow;
        logic [GAIN_W-1:0]       start_gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        line_threshold:  8'sd28,
        prop_gain_fast:  16'd3686,
        integ_gain_fast: 16'd4915,
        deriv_gain_fast: 16'd197,
        prop_gain_slow:  16'd4547,
        integ_gain_slow: 16'd16220,
        deriv_gain_slow: 16'd328,
        start_gain:      16'd1434
    };

    // control word fields
    typedef enum logic [2:0] {A_KP, A_KI, A_KD, A_KS, A_U, A_DIV} t_asel;
    typedef enum logic [2:0] {B_ERR, B_D250, B_SQ, B_SR, B_RECIP, B_QEST} t_bsel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD_PROD, ACC_ADD_QFIX} t_accop;
    typedef enum logic [1:0] {AUX_NONE, AUX_SUM_UPD, AUX_LOAD_U, AUX_LOAD_Q} t_aux;
    typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_STOPPED, J_STARTING} t_jump;

    typedef struct packed {
        t_asel            a_sel;
        t_bsel            b_sel;
        t_accop           acc_op;
        t_aux             aux;
        t_jump            jump;
        logic [PC_W-1:0]  target;
        logic             fin;
    } t_uword;

    typedef struct packed {
        logic stopped;
        logic starting;
    } t_dpstat;

    // program addresses
    localparam logic [PC_W-1:0] S_SUM   = 4'd0;
    localparam logic [PC_W-1:0] S_RMUL  = 4'd1;
    localparam logic [PC_W-1:0] S_LDU   = 4'd2;
    localparam logic [PC_W-1:0] S_RCP   = 4'd3;
    localparam logic [PC_W-1:0] S_LDQ   = 4'd4;
    localparam logic [PC_W-1:0] S_QMUL  = 4'd5;
    localparam logic [PC_W-1:0] S_QFIX  = 4'd6;
    localparam logic [PC_W-1:0] S_FIN   = 4'd7;
    localparam logic [PC_W-1:0] S_START = 4'd8;
    localparam logic [PC_W-1:0] S_SADD  = 4'd9;

    localparam t_uword UW_NOP = '{
        a_sel: A_KP, b_sel: B_ERR, acc_op: ACC_HOLD, aux: AUX_NONE,
        jump: J_NEXT, target: S_SUM, fin: 1'b0
    };

    function automatic t_uword uw(input t_asel a, input t_bsel b, input t_accop acc,
                                  input t_aux aux, input t_jump j,
                                  input logic [PC_W-1:0] tgt, input logic fin);
        t_uword w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.acc_op = acc;
        w.aux    = aux;
        w.jump   = j;
        w.target = tgt;
        w.fin    = fin;
        return w;
    endfunction

    // microprogram; each product is registered in the product register before the accumulator takes it
    function automatic t_uword urom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_SUM:   w = uw(A_KP,  B_ERR,   ACC_CLEAR,    AUX_SUM_UPD, J_STOPPED,  S_FIN,   1'b0);
            S_RMUL:  w = uw(A_KI,  B_SR,    ACC_ADD_PROD, AUX_NONE,    J_STARTING, S_START, 1'b0);
            S_LDU:   w = uw(A_KD,  B_D250,  ACC_HOLD,     AUX_LOAD_U,  J_NEXT,     S_SUM,   1'b0);
            S_RCP:   w = uw(A_U,   B_RECIP, ACC_ADD_PROD, AUX_NONE,    J_NEXT,     S_SUM,   1'b0);
            S_LDQ:   w = uw(A_KI,  B_SQ,    ACC_HOLD,     AUX_LOAD_Q,  J_NEXT,     S_SUM,   1'b0);
            S_QMUL:  w = uw(A_DIV, B_QEST,  ACC_ADD_PROD, AUX_NONE,    J_NEXT,     S_SUM,   1'b0);
            S_QFIX:  w = uw(A_KP,  B_ERR,   ACC_ADD_QFIX, AUX_NONE,    J_NEXT,     S_SUM,   1'b0);
            S_FIN:   w = uw(A_KP,  B_ERR,   ACC_HOLD,     AUX_NONE,    J_NEXT,     S_SUM,   1'b1);
            S_START: w = uw(A_KS,  B_ERR,   ACC_CLEAR,    AUX_NONE,    J_NEXT,     S_SUM,   1'b0);
            S_SADD:  w = uw(A_KP,  B_ERR,   ACC_ADD_PROD, AUX_NONE,    J_ALWAYS,   S_FIN,   1'b0);
            default: w = uw(A_KP,  B_ERR,   ACC_HOLD,     AUX_NONE,    J_NEXT,     S_SUM,   1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== design/gsps_in_if.sv =====
// sample channel: valid / ready plus the sample payload
// depends on gsps_pkg
interface gsps_in_if import gsps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BRIGHT_W-1:0] brightness;
    logic                starting;
    logic [SEL_W-1:0]    speed_select;

    modport source (output valid, output brightness, output starting,
                    output speed_select, input ready);
    modport sink (input valid, input brightness, input starting,
                  input speed_select, output ready);
endinterface

// ===== design/gsps_out_if.sv =====
// steering channel: valid / ready plus the q8.8 direction
// depends on gsps_pkg
interface gsps_out_if import gsps_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

// ===== design/gsps_seq.sv =====
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on gsps_pkg
module gsps_seq import gsps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_out_free,
    input  t_dpstat i_stat,
    output logic    o_busy,
    output logic    o_fire,
    output t_uword  o_uword
);

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_word;
    logic            w_taken;

    always_comb begin
        w_word  = urom(r_pc);
        w_taken = (w_word.jump == J_ALWAYS)
                || ((w_word.jump == J_STOPPED) && i_stat.stopped)
                || ((w_word.jump == J_STARTING) && i_stat.starting);
        o_uword = r_busy ? w_word : UW_NOP;
        o_fire  = r_busy && w_word.fin && i_out_free;
        o_busy  = r_busy;

        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = S_SUM;
        end else if (r_busy) begin
            if (w_word.fin) begin
                // hold on the final step until the output register frees up
                if (i_out_free) begin
                    n_busy = 1'b0;
                end
            end else begin
                n_pc = w_taken ? w_word.target : PC_W'(r_pc + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= S_SUM;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

// ===== design/gsps_dp.sv =====
// datapath: error history, split error sum, shared multiplier, accumulator
// depends on gsps_pkg; driven by the control word of gsps_seq
module gsps_dp import gsps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_uword                  i_ctrl,
    input  logic                    i_load,
    input  logic [BRIGHT_W-1:0]     i_brightness,
    input  logic                    i_starting,
    input  logic [SEL_W-1:0]        i_speed_select,
    input  t_cfg                    i_cfg,
    output t_dpstat                 o_stat,
    output logic signed [DIR_W-1:0] o_direction
);

    // per-sample registers
    logic signed [ERR_W-1:0] r_err;
    logic [SEL_W-1:0]        r_sel;
    logic                    r_start;

    // controller state
    logic signed [ERR_W-1:0] r_prev;
    logic signed [SQ_W-1:0]  r_sq;
    logic [SR_W-1:0]         r_sr;

    // working registers
    logic signed [D_W-1:0]   r_d250;
    logic [U_W-1:0]          r_u;
    logic [Q_W-1:0]          r_q;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [P_W-1:0]    n_prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [SQ_W-1:0]   n_sq;
    logic [SR_W-1:0]          n_sr;
    logic signed [D_W-1:0]    n_d250;
    logic [U_W-1:0]           n_u;

    logic [GAIN_W-1:0]        w_kp, w_ki, w_kd;
    logic signed [A_W-1:0]    w_a;
    logic signed [B_W-1:0]    w_b;
    logic signed [DIFF_W-1:0] w_delta, w_diff;
    logic signed [DIFF_W:0]   w_tsr;
    logic signed [2:0]        w_qinc;
    logic signed [SQ_W-1:0]   w_sq_adj;
    logic [SR_W-1:0]          w_sr_adj;
    logic [U_W-1:0]           w_rem;
    logic                     w_fix;
    logic signed [C_W-1:0]    w_clamp;
    logic signed [C_W:0]      w_rnd;

    localparam logic signed [ACC_W-1:0] ACC_LIM  = ACC_W'(DIR_LIMIT);
    localparam logic signed [ACC_W-1:0] ACC_NLIM = ACC_W'(-DIR_LIMIT);

    assign n_err = $signed({2'b00, i_brightness}) - ERR_W'(i_cfg.line_threshold);

    // gain set
    always_comb begin
        case (r_sel)
            SEL_FAST: begin
                w_kp = i_cfg.prop_gain_fast;
                w_ki = i_cfg.integ_gain_fast;
                w_kd = i_cfg.deriv_gain_fast;
            end
            SEL_SLOW: begin
                w_kp = i_cfg.prop_gain_slow;
                w_ki = i_cfg.integ_gain_slow;
                w_kd = i_cfg.deriv_gain_slow;
            end
            default: begin
                w_kp = UNITY_GAIN;
                w_ki = '0;
                w_kd = '0;
            end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (i_ctrl.a_sel)
            A_KP:    w_a = A_W'(w_kp);
            A_KI:    w_a = A_W'(w_ki);
            A_KD:    w_a = A_W'(w_kd);
            A_KS:    w_a = A_W'(i_cfg.start_gain);
            A_U:     w_a = A_W'(r_u);
            A_DIV:   w_a = A_W'(SUM_DIV);
            default: w_a = '0;
        endcase
        case (i_ctrl.b_sel)
            B_ERR:   w_b = B_W'(r_err);
            B_D250:  w_b = B_W'(r_d250);
            B_SQ:    w_b = B_W'(r_sq);
            B_SR:    w_b = B_W'(r_sr);
            B_RECIP: w_b = B_W'(RECIP_500);
            B_QEST:  w_b = B_W'(r_q);
            default: w_b = '0;
        endcase
        n_prod = w_a * w_b;
    end

    // sum update in quotient / remainder form, saturating
    always_comb begin
        w_delta = DIFF_W'(r_err) + DIFF_W'(r_prev);
        w_diff  = DIFF_W'(r_err) - DIFF_W'(r_prev);
        w_tsr   = $signed({2'b00, r_sr}) + (DIFF_W + 1)'(w_delta);
        if (w_tsr < 0) begin
            w_sr_adj = SR_W'(w_tsr + (DIFF_W + 1)'(SUM_DIV));
            w_qinc   = -3'sd1;
        end else if (w_tsr >= (DIFF_W + 1)'(2 * SUM_DIV)) begin
            w_sr_adj = SR_W'(w_tsr - (DIFF_W + 1)'(2 * SUM_DIV));
            w_qinc   = 3'sd2;
        end else if (w_tsr >= (DIFF_W + 1)'(SUM_DIV)) begin
            w_sr_adj = SR_W'(w_tsr - (DIFF_W + 1)'(SUM_DIV));
            w_qinc   = 3'sd1;
        end else begin
            w_sr_adj = SR_W'(w_tsr);
            w_qinc   = 3'sd0;
        end
        w_sq_adj = r_sq + SQ_W'(w_qinc);
        if ((w_sq_adj > SQ_MAX) || ((w_sq_adj == SQ_MAX) && (w_sr_adj > SR_MAX))) begin
            n_sq = SQ_MAX;
            n_sr = SR_MAX;
        end else if ((w_sq_adj < SQ_MIN) || ((w_sq_adj == SQ_MIN) && (w_sr_adj < SR_MIN))) begin
            n_sq = SQ_MIN;
            n_sr = SR_MIN;
        end else begin
            n_sq = w_sq_adj;
            n_sr = w_sr_adj;
        end
        // 250 * diff as shifts
        n_d250 = (D_W'(w_diff) <<< 8) - (D_W'(w_diff) <<< 2) - (D_W'(w_diff) <<< 1);
    end

    // remainder numerator with half-step bias, one less for a negative sum
    assign n_u = r_prod[U_W-1:0]
               + (r_sq[SQ_W-1] ? U_W'(ROUND_BIAS - 1) : U_W'(ROUND_BIAS));

    // quotient correction
    assign w_rem = r_u - r_prod[U_W-1:0];
    assign w_fix = (w_rem >= U_W'(SUM_DIV));

    always_comb begin
        case (i_ctrl.acc_op)
            ACC_CLEAR:    n_acc = '0;
            ACC_ADD_PROD: n_acc = r_acc + ACC_W'(r_prod);
            ACC_ADD_QFIX: n_acc = r_acc + ACC_W'(r_q) + ACC_W'(w_fix);
            default:      n_acc = r_acc;
        endcase
    end

    // clamp, negate and round to q8.8
    always_comb begin
        if (r_acc > ACC_LIM) begin
            w_clamp = C_W'(DIR_LIMIT);
        end else if (r_acc < ACC_NLIM) begin
            w_clamp = C_W'(-DIR_LIMIT);
        end else begin
            w_clamp = r_acc[C_W-1:0];
        end
        w_rnd = ((w_clamp > 0) ? (C_W + 1)'(Q88_BIAS - 1) : (C_W + 1)'(Q88_BIAS))
              - (C_W + 1)'(w_clamp);
        o_direction = DIR_W'(w_rnd >>> Q88_SHIFT);
    end

    assign o_stat.stopped  = (r_sel == SEL_STOP);
    assign o_stat.starting = r_start;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err   <= n_err;
            r_sel   <= i_speed_select;
            r_start <= i_starting;
        end
        r_prod <= n_prod;
        r_acc  <= n_acc;
        if (i_ctrl.aux == AUX_SUM_UPD) begin
            r_d250 <= n_d250;
        end
        if (i_ctrl.aux == AUX_LOAD_U) begin
            r_u <= n_u;
        end
        if (i_ctrl.aux == AUX_LOAD_Q) begin
            r_q <= r_prod[RECIP_SHIFT +: Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sq   <= '0;
            r_sr   <= '0;
        end else if (i_ctrl.aux == AUX_SUM_UPD) begin
            r_prev <= r_err;
            r_sq   <= n_sq;
            r_sr   <= n_sr;
        end
    end

endmodule

// ===== design/gain_scheduled_pid_steering.sv =====
// gain scheduled pid steering controller, top level
// a new sample is taken only once the program for the last one has finished; the pid, start
//   and stopped modes take different paths through the program; a full output register adds stall
// the shared 27x28 multiplier walked by the microprogram sets the step count
// reset: synchronous active low, clears sequencer, output valid, error history and sum,
//   loads register defaults; depends on gsps_pkg, gsps_in_if, gsps_out_if, gsps_seq, gsps_dp
`include "gain_scheduled_pid_steering_macros.svh"

module gain_scheduled_pid_steering import gsps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gsps_in_if.sink               i_sample,
    gsps_out_if.source            o_steer
);

    t_cfg                    r_cfg;
    logic                    r_out_valid;
    logic signed [DIR_W-1:0] r_dir;

    logic                    w_busy;
    logic                    w_fire;
    logic                    w_accept;
    logic                    w_out_free;
    t_uword                  w_uword;
    t_dpstat                 w_stat;
    logic signed [DIR_W-1:0] w_dir;

    // one sample at a time: ready whenever the sequencer is idle
    assign i_sample.ready = !w_busy;
    assign w_accept       = i_sample.valid && !w_busy;

    // output slot frees when empty or drained this cycle
    assign w_out_free = !r_out_valid || o_steer.ready;

    assign o_steer.valid     = r_out_valid;
    assign o_steer.direction = r_dir;

    // register file, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:  r_cfg.line_threshold  <= i_cfg_data[THR_W-1:0];
                REG_PROP_FAST:  r_cfg.prop_gain_fast  <= i_cfg_data;
                REG_INTEG_FAST: r_cfg.integ_gain_fast <= i_cfg_data;
                REG_DERIV_FAST: r_cfg.deriv_gain_fast <= i_cfg_data;
                REG_PROP_SLOW:  r_cfg.prop_gain_slow  <= i_cfg_data;
                REG_INTEG_SLOW: r_cfg.integ_gain_slow <= i_cfg_data;
                REG_DERIV_SLOW: r_cfg.deriv_gain_slow <= i_cfg_data;
                REG_START_GAIN: r_cfg.start_gain      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // microprogram control
    gsps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_busy     (w_busy),
        .o_fire     (w_fire),
        .o_uword    (w_uword)
    );

    // arithmetic and controller state
    gsps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_uword),
        .i_load         (w_accept),
        .i_brightness   (i_sample.brightness),
        .i_starting     (i_sample.starting),
        .i_speed_select (i_sample.speed_select),
        .i_cfg          (r_cfg),
        .o_stat         (w_stat),
        .o_direction    (w_dir)
    );

    // output register, loaded on the final step of the program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_steer.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_dir <= w_dir;
        end
    end

    // checks
    `GSPS_ASSERT_SAME(a_busy_blocks_input, i_clk, i_rst_n, w_busy, !i_sample.ready, "sample ready while program runs")
    `GSPS_ASSERT_NEXT(a_accept_starts_program, i_clk, i_rst_n, i_sample.valid && i_sample.ready, w_busy, "accepted beat did not start the program")
    `GSPS_ASSERT_SAME(a_direction_in_range, i_clk, i_rst_n, o_steer.valid, (o_steer.direction <= DIR_W'(DIR_Q88_MAX)) && (o_steer.direction >= DIR_W'(-DIR_Q88_MAX)), "direction beyond clamp")

endmodule

// ===== test/gain_scheduled_pid_steering_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the gain scheduled pid steering controller
// drives sample beats and register writes, checks every steering beat against a local model or a planned value
// depends on gsps_pkg, gsps_in_if, gsps_out_if and gain_scheduled_pid_steering
module gain_scheduled_pid_steering_tb;
    import gsps_pkg::*;

    // speed select three runs with unity proportional gain only
    localparam logic [SEL_W-1:0] SEL_UNITY = 2'd3;

    localparam longint PAIR_SUM_MAX = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint PAIR_SUM_MIN = -PAIR_SUM_MAX - 1;
    localparam longint INTEG_DIV    = 500;
    localparam longint CMD_CLAMP    = 409600;
    localparam longint Q12_TO_Q88   = 16;
    localparam int     GAP_MAX      = 17;
    localparam int     QUIET_LIMIT  = 4000;
    localparam int     TAIL_CYCLES  = 12;
    localparam int     PHASE_ITEMS  = 100;

    // random register styles
    localparam int STYLE_FULL    = 1;
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_MODEST  = 3;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [BRIGHT_W-1:0]     bright;
        logic                    starting;
        logic [SEL_W-1:0]        sel;
        logic                    has_exp;
        logic signed [DIR_W-1:0] exp_dir;
    } t_row;

    // directed plan: register writes only happen once the pipe is empty
    localparam int PLAN_LEN = 45;
    localparam t_row PLAN [PLAN_LEN] = '{
        // stopped mode straight out of reset, state still moves
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd0,   1'b0, SEL_STOP,  1'b1, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b0, SEL_STOP,  1'b1, 16'sd0},
        // full pid on both gain sets and unity select
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd28,  1'b0, SEL_SLOW,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd100, 1'b0, SEL_FAST,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd0,   1'b0, SEL_FAST,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd64,  1'b0, SEL_UNITY, 1'b0, 16'sd0},
        // start mode under every select, the stopped one included
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b1, SEL_UNITY, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd0,   1'b1, SEL_SLOW,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b1, SEL_FAST,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd85,  1'b1, SEL_STOP,  1'b1, 16'sd0},
        // most negative threshold and full start gain: clamps low
        '{ROW_CFG,  REG_THRESHOLD,  16'h0080, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_START_GAIN, 16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b1, SEL_FAST,  1'b1, -16'sd25600},
        // most positive threshold: clamps high
        '{ROW_CFG,  REG_THRESHOLD,  16'h007F, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd0,   1'b1, SEL_SLOW,  1'b1, 16'sd25600},
        // zero start gain kills the start command
        '{ROW_CFG,  REG_START_GAIN, 16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd99,  1'b1, SEL_FAST,  1'b1, 16'sd0},
        // every pid gain at full scale
        '{ROW_CFG,  REG_THRESHOLD,  16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_PROP_FAST,  16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_INTEG_FAST, 16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_DERIV_FAST, 16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_PROP_SLOW,  16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_INTEG_SLOW, 16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_DERIV_SLOW, 16'hFFFF, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b0, SEL_FAST,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd0,   1'b0, SEL_SLOW,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b0, SEL_FAST,  1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd42,  1'b0, SEL_UNITY, 1'b0, 16'sd0},
        // every pid gain at zero: only the unity select still steers
        '{ROW_CFG,  REG_PROP_FAST,  16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_INTEG_FAST, 16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_DERIV_FAST, 16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_PROP_SLOW,  16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_INTEG_SLOW, 16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG,  REG_DERIV_SLOW, 16'h0000, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd127, 1'b0, SEL_FAST,  1'b1, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd1,   1'b0, SEL_SLOW,  1'b1, 16'sd0},
        '{ROW_BEAT, REG_THRESHOLD, 16'd0, 7'd2,   1'b0, SEL_UNITY, 1'b0, 16'sd0},
        // back to the reset values for the first random phase
        '{ROW_CFG, REG_THRESHOLD, {8'd0, CFG_RESET.line_threshold},
          7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_PROP_FAST,  CFG_RESET.prop_gain_fast,  7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_INTEG_FAST, CFG_RESET.integ_gain_fast, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_DERIV_FAST, CFG_RESET.deriv_gain_fast, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_PROP_SLOW,  CFG_RESET.prop_gain_slow,  7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_INTEG_SLOW, CFG_RESET.integ_gain_slow, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_DERIV_SLOW, CFG_RESET.deriv_gain_slow, 7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0},
        '{ROW_CFG, REG_START_GAIN, CFG_RESET.start_gain,      7'd0, 1'b0, SEL_STOP, 1'b0, 16'sd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gsps_in_if  sample_ch ();
    gsps_out_if steer_ch ();

    gain_scheduled_pid_steering u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_ch),
        .o_steer    (steer_ch)
    );

    // local copy of the registers and the controller history
    t_cfg                     ctl_regs;
    logic signed [ERR_W-1:0]  last_error;
    logic signed [SUM_BITS-1:0] error_sum;

    // steering values still owed by the block, oldest first
    logic signed [DIR_W-1:0] direction_q [$];
    int                      mismatch_count = 0;
    int                      quiet_cycles = 0;
    bit                      send_idle_on = 1'b1;
    bit                      recv_idle_on = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // divide by a positive divisor, nearest, ties away from zero
    function automatic longint round_half_away(input longint x, input longint d);
        if (x >= 0) begin
            return (x + d / 2) / d;
        end
        return -((-x + d / 2) / d);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD:  ctl_regs.line_threshold  = data[THR_W-1:0];
            REG_PROP_FAST:  ctl_regs.prop_gain_fast  = data;
            REG_INTEG_FAST: ctl_regs.integ_gain_fast = data;
            REG_DERIV_FAST: ctl_regs.deriv_gain_fast = data;
            REG_PROP_SLOW:  ctl_regs.prop_gain_slow  = data;
            REG_INTEG_SLOW: ctl_regs.integ_gain_slow = data;
            REG_DERIV_SLOW: ctl_regs.deriv_gain_slow = data;
            REG_START_GAIN: ctl_regs.start_gain      = data;
            default: ;
        endcase
    endfunction

    // steering command for one sample; advances the error history and sum
    function automatic logic signed [DIR_W-1:0] predict_direction(
        input logic [BRIGHT_W-1:0] bright,
        input logic                starting,
        input logic [SEL_W-1:0]    sel
    );
        longint err, prev, sum, kp, ki, kd, cmd;
        err  = longint'(bright) - longint'(ctl_regs.line_threshold);
        prev = longint'(last_error);
        sum  = longint'(error_sum) + err + prev;
        if (sum > PAIR_SUM_MAX) sum = PAIR_SUM_MAX;
        if (sum < PAIR_SUM_MIN) sum = PAIR_SUM_MIN;
        error_sum  = sum[SUM_BITS-1:0];
        last_error = err[ERR_W-1:0];

        case (sel)
            SEL_FAST: begin
                kp = longint'(ctl_regs.prop_gain_fast);
                ki = longint'(ctl_regs.integ_gain_fast);
                kd = longint'(ctl_regs.deriv_gain_fast);
            end
            SEL_SLOW: begin
                kp = longint'(ctl_regs.prop_gain_slow);
                ki = longint'(ctl_regs.integ_gain_slow);
                kd = longint'(ctl_regs.deriv_gain_slow);
            end
            default: begin
                kp = longint'(UNITY_GAIN);
                ki = 0;
                kd = 0;
            end
        endcase

        // all terms in q12, negated before the clamp
        if (sel == SEL_STOP) begin
            cmd = 0;
        end else if (starting) begin
            cmd = -(longint'(ctl_regs.start_gain) * err);
        end else begin
            cmd = -(kp * err + round_half_away(ki * sum, INTEG_DIV) + kd * 250 * (err - prev));
        end
        if (cmd > CMD_CLAMP) cmd = CMD_CLAMP;
        if (cmd < -CMD_CLAMP) cmd = -CMD_CLAMP;
        cmd = round_half_away(cmd, Q12_TO_Q88);
        return cmd[DIR_W-1:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx,
                                                             input int style);
        logic [CFG_DATA_W-1:0] v;
        case (style)
            STYLE_FULL:    v = CFG_DATA_W'($urandom_range(0, 65535));
            STYLE_EXTREME: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            STYLE_MODEST:  v = CFG_DATA_W'($urandom_range(0, 8191));
            default:       v = CFG_DATA_W'($urandom_range(0, 65535));
        endcase
        // threshold extremes are the signed ends, modest keeps it inside the percent range
        if (idx == REG_THRESHOLD) begin
            case (style)
                STYLE_FULL:    v = CFG_DATA_W'($urandom_range(0, 255));
                STYLE_EXTREME: v = $urandom_range(0, 1) ? 16'h0080 : 16'h007F;
                STYLE_MODEST:  v = CFG_DATA_W'($urandom_range(0, 100));
                default:       v = CFG_DATA_W'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    // all tasks start and end on a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // hold the sample side idle until every owed steering beat has come back
    task automatic drain_pipe();
        sample_ch.valid = 1'b0;
        while (direction_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [BRIGHT_W-1:0] bright, input logic starting,
                               input logic [SEL_W-1:0] sel, input logic has_exp,
                               input logic signed [DIR_W-1:0] exp_dir);
        int                      gap;
        logic signed [DIR_W-1:0] predicted;
        gap = send_idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid        = 1'b1;
        sample_ch.brightness   = bright;
        sample_ch.starting     = starting;
        sample_ch.speed_select = sel;
        do @(posedge i_clk); while (!sample_ch.ready);
        // model always runs so the history stays in step with the block
        predicted = predict_direction(bright, starting, sel);
        direction_q.push_back(has_exp ? exp_dir : predicted);
        @(negedge i_clk);
    endtask

    // steering side: random stall before every beat, then compare on accept
    initial begin
        int                      stall;
        logic signed [DIR_W-1:0] expected;
        steer_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = recv_idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                steer_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            steer_ch.ready = 1'b1;
            do @(posedge i_clk); while (steer_ch.valid !== 1'b1);
            if (direction_q.size() == 0) begin
                $display("%0t ns: steering beat with nothing owed, expected none actual %0d",
                         $time, steer_ch.direction);
                mismatch_count++;
            end else begin
                expected = direction_q.pop_front();
                if (steer_ch.direction !== expected) begin
                    $display("%0t ns: direction mismatch, expected %0d actual %0d",
                             $time, expected, steer_ch.direction);
                    mismatch_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // watchdog: too long without any beat on either side means a hang
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (steer_ch.valid && steer_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int                    row;
        int                    phase;
        int                    n;
        int                    run_left;
        int                    run_mode;
        int                    near;
        logic [SEL_W-1:0]      run_sel;
        logic [BRIGHT_W-1:0]   bright;
        logic                  starting;
        logic [SEL_W-1:0]      sel;
        logic [CFG_IDX_W-1:0]  idx;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = REG_THRESHOLD;
        i_cfg_data             = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.brightness   = '0;
        sample_ch.starting     = 1'b0;
        sample_ch.speed_select = SEL_STOP;
        ctl_regs               = CFG_RESET;
        last_error             = '0;
        error_sum              = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        for (row = 0; row < PLAN_LEN; row++) begin
            if (PLAN[row].kind == ROW_CFG) begin
                drain_pipe();
                write_reg(PLAN[row].idx, PLAN[row].data);
            end else begin
                send_sample(PLAN[row].bright, PLAN[row].starting, PLAN[row].sel,
                            PLAN[row].has_exp, PLAN[row].exp_dir);
            end
        end

        // random part: reset gains first, then full range, extremes and modest gains
        for (phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                drain_pipe();
                for (n = 0; n < 8; n++) begin
                    idx = n[CFG_IDX_W-1:0];
                    write_reg(idx, pick_reg_value(idx, phase));
                end
            end
            run_left = 0;
            run_sel  = SEL_FAST;
            run_mode = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // stretches with and without idling on each side
                if (n % 25 == 0) begin
                    send_idle_on = ($urandom_range(0, 3) != 0);
                    recv_idle_on = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 29) == 0) begin
                    drain_pipe();
                end
                if (run_left == 0) begin
                    run_left = $urandom_range(4, 16);
                    run_mode = $urandom_range(0, 9);
                    run_sel  = $urandom_range(0, 1) ? SEL_FAST : SEL_SLOW;
                end
                run_left--;

                case ($urandom_range(0, 9))
                    7: bright = BRIGHT_W'($urandom_range(101, 127));
                    8: bright = $urandom_range(0, 1) ? 7'd127 : 7'd0;
                    9: begin
                        // hover around the line so the error changes sign
                        near = int'(ctl_regs.line_threshold) + int'($urandom_range(0, 6)) - 3;
                        if (near < 0) near = 0;
                        if (near > 127) near = 127;
                        bright = near[BRIGHT_W-1:0];
                    end
                    default: bright = BRIGHT_W'($urandom_range(0, 100));
                endcase

                // mostly steady pid runs so the integral builds up
                if (run_mode < 6) begin
                    sel      = run_sel;
                    starting = ($urandom_range(0, 19) == 0);
                end else if (run_mode < 8) begin
                    starting = 1'b1;
                    case ($urandom_range(0, 2))
                        0:       sel = SEL_SLOW;
                        1:       sel = SEL_FAST;
                        default: sel = SEL_UNITY;
                    endcase
                end else if (run_mode == 8) begin
                    sel      = SEL_STOP;
                    starting = 1'($urandom_range(0, 1));
                end else begin
                    sel      = SEL_W'($urandom_range(0, 3));
                    starting = 1'($urandom_range(0, 1));
                end
                send_sample(bright, starting, sel, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
